// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion shorthands
// Implication helpers for same-cycle and next-cycle checks, with reset
// disable. Define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/ttd_pkg.sv
// ----------------------------------------------------------------------------
// ttd_pkg: shared types and constants of the tap detector
// History depth, field widths, register codes and the transaction structs.
// ----------------------------------------------------------------------------
package ttd_pkg;

	localparam int HIST_DEPTH = 32;
	localparam int IDX_W      = $clog2(HIST_DEPTH);
	localparam int COORD_W    = 16;
	localparam int WIN_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [COORD_W-1:0] DIST_RESET = COORD_W'(5);
	localparam logic [WIN_W-1:0]   WIN_RESET  = WIN_W'(8);

	localparam logic [CFG_IDX_W-1:0] CFG_TAP_DISTANCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW   = CFG_IDX_W'(1);

	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} sample_t;

	typedef struct packed {
		logic               touch_present;
		logic [COORD_W-1:0] touch_x;
		logic [COORD_W-1:0] touch_y;
	} tap_in_t;

	typedef struct packed {
		logic               tap_found;
		logic [COORD_W-1:0] tap_x;
		logic [COORD_W-1:0] tap_y;
		logic               touch_active;
	} tap_out_t;

	// control from the sequencer to the window checker
	typedef struct packed {
		logic start;
		logic step;
	} chk_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_WALK   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

endpackage

// File: hw/rtl/ttd_cell.sv
// ----------------------------------------------------------------------------
// ttd_cell: one history entry of the sample ring
// Takes either a fresh sample or its neighbor's entry when the ring shifts.
// ----------------------------------------------------------------------------
module ttd_cell import ttd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift,
	input  logic    load,
	input  sample_t sample_in,
	input  sample_t neigh_in,
	output sample_t entry
);

	sample_t d;
	logic    valid_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;

	assign d = load ? sample_in : neigh_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			x_q <= d.x;
			y_q <= d.y;
		end
	end

	assign entry = '{valid: valid_q, x: x_q, y: y_q};

endmodule

// File: hw/rtl/ttd_window.sv
// ----------------------------------------------------------------------------
// ttd_window: tap window checker
// Holds the candidate point and folds each entry passing the ring tap into
// the tap verdict and the all-empty flag.
// ----------------------------------------------------------------------------
module ttd_window import ttd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  chk_ctrl_t          ctrl,
	input  sample_t            cand_in,
	input  sample_t            entry,
	input  logic [IDX_W-1:0]   offset,
	input  logic [COORD_W-1:0] tap_distance,
	input  logic [WIN_W-1:0]   tap_window,
	output logic               tap_ok,
	output logic               all_empty,
	output sample_t            cand
);

	sample_t cand_q;
	logic    ok_q;
	logic    empty_q;
	logic    covered;
	logic    near;
	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;

	// offsets 1 .. window+1 back from the newest entry; a window that
	// reaches around the ring covers every entry
	assign covered = ((int'(offset) >= 1) && (int'(offset) <= int'(tap_window) + 1))
		|| (int'(tap_window) + 1 >= HIST_DEPTH);

	assign dx = (cand_q.x > entry.x) ? cand_q.x - entry.x : entry.x - cand_q.x;
	assign dy = (cand_q.y > entry.y) ? cand_q.y - entry.y : entry.y - cand_q.y;
	assign near = entry.valid && (dx <= tap_distance) && (dy <= tap_distance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q    <= 1'b0;
			empty_q <= 1'b0;
		end else if (ctrl.start) begin
			ok_q    <= 1'b1;
			empty_q <= 1'b1;
		end else if (ctrl.step) begin
			ok_q    <= ok_q && (!covered || near);
			empty_q <= empty_q && !entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			cand_q <= cand_in;
		end
	end

	assign tap_ok    = ok_q;
	assign all_empty = empty_q;
	assign cand      = cand_q;

endmodule

// File: hw/rtl/touch_tap_detector.sv
// ----------------------------------------------------------------------------
// touch_tap_detector: tap gesture recognizer over a ring of touch samples
// A lift during an active touch walks the whole ring, one entry a cycle;
// every other sample is answered directly.
// ----------------------------------------------------------------------------
// The sample is shifted into the ring on acceptance and ST_FINISH loads the
// result; a lift while active first rotates the ring through the checker
// tap in ST_WALK. No new sample is taken until the result has been loaded.
// A new sample is taken while the previous result still waits at the output.
// Reset clears all entry valid bits at once, the touch session flag and the
// output valid flag; tap_distance returns to 5, tap_window to 8.
module touch_tap_detector import ttd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  tap_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output tap_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	`include "assert_macros.svh"

	state_t             state_q;
	logic [IDX_W-1:0]   step_q;
	logic               session_q;
	logic               walked_q;
	logic [COORD_W-1:0] dist_q;
	logic [WIN_W-1:0]   win_q;
	tap_out_t           out_q;
	logic               out_valid_q;

	logic      accept;
	logic      need_walk;
	logic      last_step;
	logic      load_out;
	logic      ring_shift;
	sample_t   new_sample;
	sample_t   ring [HIST_DEPTH];
	sample_t   neigh [HIST_DEPTH];
	chk_ctrl_t chk_ctrl;
	logic      tap_ok;
	logic      all_empty;
	sample_t   cand;
	logic [IDX_W-1:0] offset;
	tap_out_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= DIST_RESET;
			win_q  <= WIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TAP_DISTANCE: dist_q <= cfg_data;
				CFG_TAP_WINDOW:   win_q  <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign need_walk = !in_data.touch_present && session_q;
	assign last_step = (step_q == IDX_W'(HIST_DEPTH - 1));
	assign load_out  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	// the ring shifts once to take a sample, then rotates a full turn on a walk
	assign ring_shift = accept || (state_q == ST_WALK);
	assign new_sample = in_data.touch_present
		? sample_t'{valid: 1'b1, x: in_data.touch_x, y: in_data.touch_y}
		: sample_t'{valid: 1'b0, x: '0, y: '0};

	always_comb begin
		neigh[0] = ring[HIST_DEPTH-1];
		for (int k = 1; k < HIST_DEPTH; k++) begin
			neigh[k] = ring[k-1];
		end
	end

	for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
		ttd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (ring_shift),
			.load      ((k == 0) && accept),
			.sample_in (new_sample),
			.neigh_in  (neigh[k]),
			.entry     (ring[k])
		);
	end

	// the last cell holds the entry HIST_DEPTH-1-step places behind the newest
	assign offset         = IDX_W'(HIST_DEPTH - 1) - step_q;
	assign chk_ctrl.start = accept && need_walk;
	assign chk_ctrl.step  = (state_q == ST_WALK);

	ttd_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (chk_ctrl),
		.cand_in      (ring[0]),
		.entry        (ring[HIST_DEPTH-1]),
		.offset       (offset),
		.tap_distance (dist_q),
		.tap_window   (win_q),
		.tap_ok       (tap_ok),
		.all_empty    (all_empty),
		.cand         (cand)
	);

	always_comb begin
		res.tap_found    = walked_q && tap_ok;
		res.tap_x        = res.tap_found ? cand.x : '0;
		res.tap_y        = res.tap_found ? cand.y : '0;
		res.touch_active = walked_q ? !all_empty : session_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			session_q <= 1'b0;
			walked_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						walked_q <= need_walk;
						step_q   <= '0;
						if (in_data.touch_present) begin
							session_q <= 1'b1;
						end
						state_q <= need_walk ? ST_WALK : ST_FINISH;
					end
				end
				ST_WALK: begin
					step_q <= step_q + IDX_W'(1);
					if (last_step) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						session_q <= res.touch_active;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_NEXT(a_walk_start, clk, arst_n, accept && need_walk,
		(state_q == ST_WALK) && (step_q == '0))
	`ASSERT_NEXT(a_walk_end, clk, arst_n, (state_q == ST_WALK) && last_step,
		state_q == ST_FINISH)
	`ASSERT_IMPL(a_tap_active, clk, arst_n, out_valid && out_data.tap_found,
		out_data.touch_active)

endmodule

// File: tb/touch_tap_detector_tb.sv
// ----------------------------------------------------------------------------
// touch_tap_detector_tb: self-checking bench for the tap detector
// A table of directed samples and register writes runs first, then phases of
// random press runs, lifts and noise under a range of distance and window
// settings. Each result is checked against the ring model or its row's want.
// ----------------------------------------------------------------------------
module touch_tap_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ttd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);
	localparam int DRAIN_CYCLES = HIST_DEPTH + 8;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		tap_in_t               smp;
		logic                  typed;
		tap_out_t              want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	tap_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	tap_out_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// ring model
	sample_t          ring [HIST_DEPTH];
	logic [IDX_W-1:0] ring_slot;
	logic             live;
	logic [15:0]      pred_dist;
	logic [WIN_W-1:0] pred_win;

	tap_out_t pending_taps [$];
	tap_out_t tap_want;
	bit       gaps_on = 1'b1;
	int       fault_count = 0;
	int       n_samples = 0;
	int       n_results = 0;
	int       n_taps = 0;
	int       n_clears = 0;
	int       n_writes = 0;

	plan_row_t directed_plan [29] = '{
		'{ROW_SAMPLE, '0, '0, '{1'b0, 16'h0000, 16'h0000}, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b0}},
		'{ROW_WRITE, CFG_TAP_WINDOW, 16'h0000, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'hFFFF, 16'hFFFF}, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b1}},
		'{ROW_SAMPLE, '0, '0, '{1'b0, 16'h0000, 16'h0000}, 1'b1,
			'{1'b1, 16'hFFFF, 16'hFFFF, 1'b1}},
		'{ROW_SAMPLE, '0, '0, '{1'b0, 16'h0000, 16'h0000}, 1'b1, '{1'b0, 16'h0, 16'h0, 1'b1}},
		'{ROW_WRITE, CFG_TAP_DISTANCE, 16'h0000, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_TAP_WINDOW, 16'h0001, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b0, 16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'h0, 16'h0, 1'b1}},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'h0001, 16'h0000}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b0, 16'h0000, 16'h0000}, 1'b0, '0},
		'{ROW_WRITE, CFG_TAP_DISTANCE, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_TAP_WINDOW, 16'h0003, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'h0000, 16'hFFFF}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'hFFFF, 16'h0000}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b0, 16'h0000, 16'h0000}, 1'b0, '0},
		'{ROW_WRITE, CFG_TAP_WINDOW, 16'h001F, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'h0100, 16'h0200}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'h0100, 16'h0200}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b1, 16'h0100, 16'h0200}, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b0, 16'h0000, 16'h0000}, 1'b0, '0},
		'{ROW_WRITE, CFG_SPARE_2, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_SPARE_3, 16'h0000, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_TAP_WINDOW, 16'hFFFE, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, '{1'b0, 16'hFFFF, 16'hFFFF}, 1'b0, '0}
	};

	touch_tap_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("touch_tap_detector test failed");
		$finish;
	end

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("ERROR: %s", msg);
	endfunction

	function automatic bit too_far(input logic [15:0] a, input logic [15:0] b);
		return ((a > b) ? (a - b) : (b - a)) > pred_dist;
	endfunction

	// store the sample, then judge a lift against the candidate point and its window
	function automatic tap_out_t next_tap_result(input tap_in_t s);
		tap_out_t         r;
		logic [IDX_W-1:0] idx;
		sample_t          cand;
		logic             hit;
		int               empties;
		r = '0;
		if (s.touch_present) begin
			ring[ring_slot] = '{1'b1, s.touch_x, s.touch_y};
			live = 1'b1;
		end else begin
			ring[ring_slot] = '0;
			if (live) begin
				idx = ring_slot - 1'b1;
				cand = ring[idx];
				hit = cand.valid;
				for (int k = 0; k < int'(pred_win) && hit; k++) begin
					idx = idx - 1'b1;
					if (!ring[idx].valid || too_far(cand.x, ring[idx].x) ||
					    too_far(cand.y, ring[idx].y))
						hit = 1'b0;
				end
				if (hit) begin
					r.tap_found = 1'b1;
					r.tap_x = cand.x;
					r.tap_y = cand.y;
				end
				empties = 0;
				for (int k = 0; k < HIST_DEPTH; k++)
					if (!ring[k].valid)
						empties++;
				if (empties == HIST_DEPTH) begin
					live = 1'b0;
					n_clears++;
				end
			end
		end
		ring_slot = ring_slot + 1'b1;
		r.touch_active = live;
		return r;
	endfunction

	// stay within the tap distance most of the time, stray just beyond it now and then
	function automatic logic [15:0] near_coord(input logic [15:0] c);
		int v;
		int reach;
		reach = int'(pred_dist);
		if ($urandom_range(0, 99) < 8) begin
			reach = reach + 1 + int'($urandom_range(0, 3));
			v = (int'(c) + reach > 65535) ? int'(c) - reach : int'(c) + reach;
		end else begin
			v = int'(c) - reach + int'($urandom_range(0, 2 * reach));
		end
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	function automatic logic [15:0] pick_anchor();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic tap_in_t lift_sample();
		return '{1'b0, 16'($urandom), 16'($urandom)};
	endfunction

	task automatic offer_sample(input tap_in_t s, input logic typed, input tap_out_t want);
		tap_out_t r;
		while (gaps_on && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = next_tap_result(s);
		if (typed)
			r = want;
		pending_taps.push_back(r);
		n_samples++;
		if (r.tap_found)
			n_taps++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_taps.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
	                              input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_TAP_DISTANCE: pred_dist = val;
			CFG_TAP_WINDOW: pred_win = val[WIN_W-1:0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input int quota);
		int          start_n;
		int          len;
		int          pick;
		logic [15:0] bx;
		logic [15:0] by;
		tap_in_t     s;
		start_n = n_samples;
		while (n_samples - start_n < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				// press run around one point, then one to three lifts
				bx = pick_anchor();
				by = pick_anchor();
				len = int'(pred_win) + 1 + int'($urandom_range(0, 3));
				if ($urandom_range(0, 4) == 0)
					len = $urandom_range(1, int'(pred_win) + 1);
				repeat (len) begin
					s = '{1'b1, near_coord(bx), near_coord(by)};
					offer_sample(s, 1'b0, '0);
				end
				repeat ($urandom_range(1, 3))
					offer_sample(lift_sample(), 1'b0, '0);
			end else if (pick < 80) begin
				// long quiet stretch empties the ring and ends the session
				repeat ($urandom_range(HIST_DEPTH, HIST_DEPTH + 3))
					offer_sample(lift_sample(), 1'b0, '0);
			end else begin
				repeat ($urandom_range(1, 8)) begin
					s = '{1'($urandom), pick_anchor(), pick_anchor()};
					offer_sample(s, 1'b0, '0);
				end
			end
		end
	endtask

	always @(negedge clk)
		out_stall <= gaps_on && ($urandom_range(0, 99) < 32);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_taps.size() == 0) begin
				note_fault($sformatf("result %0d arrived with nothing expected", n_results));
			end else begin
				tap_want = pending_taps.pop_front();
				if (out_data.tap_found !== tap_want.tap_found ||
				    out_data.tap_x !== tap_want.tap_x ||
				    out_data.tap_y !== tap_want.tap_y ||
				    out_data.touch_active !== tap_want.touch_active)
					note_fault($sformatf({"result %0d: expected found=%0b x=%h y=%h ",
						"active=%0b, got found=%0b x=%h y=%h active=%0b"}, n_results,
						tap_want.tap_found, tap_want.tap_x, tap_want.tap_y,
						tap_want.touch_active, out_data.tap_found, out_data.tap_x,
						out_data.tap_y, out_data.touch_active));
			end
		end
	end

	initial begin
		int n_directed;
		int d;
		int w;
		for (int k = 0; k < HIST_DEPTH; k++)
			ring[k] = '0;
		ring_slot = '0;
		live = 1'b0;
		pred_dist = DIST_RESET;
		pred_win = WIN_RESET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_plan[r]) begin
			if (directed_plan[r].kind == ROW_WRITE) begin
				wait_for_results();
				write_register(directed_plan[r].reg_idx, directed_plan[r].reg_val);
			end else begin
				offer_sample(directed_plan[r].smp, directed_plan[r].typed,
				             directed_plan[r].want);
			end
		end
		n_directed = n_samples;

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin d = 5;     w = 8;  end
				1: begin d = 0;     w = 1;  end
				2: begin d = 65535; w = 30; end
				3: begin d = 3;     w = 31; end
				4: begin d = 12;    w = 0;  end
				5: begin d = 100;   w = 4;  end
				default: begin
					d = $urandom_range(0, 40);
					w = $urandom_range(0, 31);
				end
			endcase
			// hold the sender until the block is idle before touching registers
			wait_for_results();
			write_register(CFG_TAP_DISTANCE, d[CFG_DATA_W-1:0]);
			write_register(CFG_TAP_WINDOW, w[CFG_DATA_W-1:0]);
			gaps_on = (ph != 2);
			run_phase(145);
		end
		gaps_on = 1'b1;

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_taps.size() != 0)
			note_fault($sformatf("%0d results never arrived", pending_taps.size()));
		$display("Ran %0d samples (%0d from the directed table) with %0d register writes.",
		         n_samples, n_directed, n_writes);
		$display("Saw %0d predicted taps, %0d session clears and %0d mismatches.",
		         n_taps, n_clears, fault_count);
		if (fault_count == 0)
			$display("touch_tap_detector test passed");
		else
			$display("touch_tap_detector test failed");
		$finish;
	end

endmodule
